FILE: hw/rtl/ppd_pkg.sv
// Shared types and constants for the PPM P6 stream decoder.
package ppd_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_SKIP_W,
      PH_NUM_W,
      PH_SKIP_H,
      PH_NUM_H,
      PH_SKIP_M,
      PH_NUM_M,
      PH_SEP,
      PH_PAYLOAD,
      PH_BAD_MAGIC
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_MAGIC  = 3'd1,
      ST_BAD_DIM    = 3'd2,
      ST_BAD_MAXVAL = 3'd3,
      ST_SIZE       = 3'd4
   } status_type;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam int unsigned MAXVAL_OK = 255;

   localparam int unsigned TDATA_BITS = 72;

   typedef struct packed {
      logic        is_status;
      logic [31:0] pixel_rgba;
      logic [2:0]  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last;
   } rsp_type;

endpackage

FILE: hw/rtl/ppm_p6_stream_decoder.sv
// Top level of the PPM P6 stream decoder.
// Takes a binary PPM (P6) file one byte per word on req_ and returns RGBA pixels (alpha 0)
// and one final status word, marked by rsp_tuser and rsp_tlast, on rsp_. Each byte
// is checked and applied in a single pass between the byte register and a two-entry result
// queue, so one byte is taken every cycle unless the queue is full; a final byte that
// completes a pixel also holds the input while its pixel and status words enter the queue
// one after the other. A result word passes through the byte register and the result queue
// before it is presented on rsp_. Dimensions saturate at 2^DIM_BITS; after the final byte
// the block is ready for the next file.
module ppm_p6_stream_decoder import ppd_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_file
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,   // [31:0] pixel_rgba, [34:32] status,
                                              // [50:35] image_width, [66:51] image_height
   output logic                  rsp_tuser,   // is_status
   output logic                  rsp_tlast    // last
);

   logic    push_valid;
   logic    push_ready;
   rsp_type push_data;
   rsp_type out_data;

   ppd_parser #(
      .DIM_BITS (DIM_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_byte   (req_tdata),
      .req_eof    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ppd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (out_data)
   );

   assign rsp_tdata = {5'b0, out_data.image_height, out_data.image_width,
                       out_data.status, out_data.pixel_rgba};
   assign rsp_tuser = out_data.is_status;
   assign rsp_tlast = out_data.last;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("result pushed into a full queue");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("status word and last flag disagree");

   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[TDATA_BITS-1:24] == '0))
      else $error("pixel word carries alpha or status bits");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[31:0] == '0 &&
         rsp_tdata[34:32] <= ST_SIZE))
      else $error("malformed status word");

endmodule

FILE: hw/rtl/ppd_parser.sv
// Byte register, header/payload parser and result selection.
module ppd_parser import ppd_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_eof,
   output logic       push_valid,
   input  logic       push_ready,
   output rsp_type    push_data
);

   localparam int FW = DIM_BITS + 1;
   localparam logic [FW-1:0] SAT    = FW'(1) << DIM_BITS;
   localparam logic [FW-1:0] MAXDIM = SAT - FW'(1);

   logic            in_v_ff;
   logic [7:0]      byte_ff;
   logic            eof_ff;

   phase_type       phase_ff, phase_in;
   logic            cmt_ff, cmt_in;
   logic [FW-1:0]   acc_ff, acc_in;
   logic [FW-1:0]   w_ff, w_in, h_ff, h_in, m_ff, m_in;
   logic [1:0]      tp_ff, tp_in;
   logic [15:0]     part_ff, part_in;
   logic [FW-1:0]   col_ff, col_in, row_ff, row_in;
   logic            over_ff, over_in;
   logic            pend_ff;
   rsp_type         pend_data_ff;

   logic            fire, pix_fire, below;
   logic            is_digit, is_space, is_hash, is_lf;
   logic [FW+3:0]   acc_ext, acc_mul;
   logic [FW-1:0]   acc_upd;
   logic [FW-1:0]   fw, fh, fm;
   logic            seen_ok;
   status_type      stat;
   rsp_type         pix_rsp, stat_rsp;

   function automatic logic [15:0] sat16(input logic [FW-1:0] v);
      logic [31:0] x;
      x = 32'(v);
      return (x > 32'h0000_FFFF) ? 16'hFFFF : x[15:0];
   endfunction

   assign fire      = in_v_ff && !pend_ff && push_ready;
   assign req_ready = !in_v_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ready) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
         eof_ff  <= req_eof;
      end
   end

   // byte classes
   assign is_hash  = byte_ff == CH_HASH;
   assign is_lf    = byte_ff == CH_LF;
   assign is_space = (byte_ff == CH_SPACE) || (byte_ff == CH_TAB) ||
                     (byte_ff == CH_CR) || is_lf;
   assign is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);

   // acc * 10 + digit, saturating at 2^DIM_BITS
   always_comb begin
      acc_ext = {4'b0, acc_ff};
      acc_mul = (acc_ext << 3) + (acc_ext << 1) +
                {{FW{1'b0}}, byte_ff[3:0] - CH_ZERO[3:0]};
      if (acc_ff[DIM_BITS] || acc_mul > {4'b0, SAT}) begin
         acc_upd = SAT;
      end else begin
         acc_upd = acc_mul[FW-1:0];
      end
   end

   // header phase: a byte that is not used up falls through to the next phase
   // in the same cycle, so every cascade is folded into one step here
   always_comb begin
      phase_in = phase_ff;
      cmt_in   = cmt_ff;
      acc_in   = acc_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      m_in     = m_ff;
      unique case (phase_ff)
         PH_MAGIC0: phase_in = (byte_ff == CH_P) ? PH_MAGIC1 : PH_BAD_MAGIC;
         PH_MAGIC1: phase_in = (byte_ff == CH_SIX) ? PH_SKIP_W : PH_BAD_MAGIC;
         PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
            if (is_hash) begin
               cmt_in = 1'b1;
            end else if (is_lf) begin
               cmt_in = 1'b0;
            end else if (is_space || cmt_ff) begin
               cmt_in = cmt_ff;
            end else if (is_digit) begin
               acc_in   = acc_upd;
               phase_in = (phase_ff == PH_SKIP_W) ? PH_NUM_W :
                          (phase_ff == PH_SKIP_H) ? PH_NUM_H : PH_NUM_M;
            end else begin
               // later fields are still zero; separator is eaten too
               phase_in = PH_PAYLOAD;
            end
         end
         PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
            if (is_digit) begin
               acc_in = acc_upd;
            end else begin
               acc_in = '0;
               cmt_in = 1'b0;
               if (phase_ff == PH_NUM_W) begin
                  w_in = acc_ff;
               end else if (phase_ff == PH_NUM_H) begin
                  h_in = acc_ff;
               end else begin
                  m_in = acc_ff;
               end
               if (phase_ff == PH_NUM_M) begin
                  phase_in = PH_PAYLOAD;
               end else if (is_hash || is_space) begin
                  cmt_in   = is_hash;
                  phase_in = (phase_ff == PH_NUM_W) ? PH_SKIP_H : PH_SKIP_M;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_SEP:       phase_in = PH_PAYLOAD;
         PH_PAYLOAD:   phase_in = PH_PAYLOAD;
         PH_BAD_MAGIC: phase_in = PH_BAD_MAGIC;
         default:      phase_in = PH_BAD_MAGIC;
      endcase
   end

   // payload position as triple / column / row counters; over marks one
   // byte beyond 3*width*height
   assign below = (w_ff != '0) && (h_ff != '0) && (row_ff < h_ff);

   always_comb begin
      tp_in    = tp_ff;
      part_in  = part_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      over_in  = over_ff;
      pix_fire = 1'b0;
      if (phase_ff == PH_PAYLOAD) begin
         if (below) begin
            case (tp_ff)
               2'd0: begin
                  part_in[7:0] = byte_ff;
                  tp_in        = 2'd1;
               end
               2'd1: begin
                  part_in[15:8] = byte_ff;
                  tp_in         = 2'd2;
               end
               default: begin
                  pix_fire = 1'b1;
                  tp_in    = 2'd0;
                  if (col_ff + FW'(1) == w_ff) begin
                     col_in = '0;
                     row_in = row_ff + FW'(1);
                  end else begin
                     col_in = col_ff + FW'(1);
                  end
               end
            endcase
         end else begin
            over_in = 1'b1;
         end
      end
   end

   // final status from the state after this byte
   always_comb begin
      fw = (phase_in == PH_NUM_W) ? acc_in : w_in;
      fh = (phase_in == PH_NUM_H) ? acc_in : h_in;
      fm = (phase_in == PH_NUM_M) ? acc_in : m_in;
      seen_ok = !over_in && ((w_in == '0) || (h_in == '0) || (row_in == h_in));
      if (phase_in == PH_BAD_MAGIC || phase_in == PH_MAGIC0 || phase_in == PH_MAGIC1) begin
         stat = ST_BAD_MAGIC;
      end else if (fw == '0 || fh == '0 || fw > MAXDIM || fh > MAXDIM) begin
         stat = ST_BAD_DIM;
      end else if (32'(fm) != MAXVAL_OK) begin
         stat = ST_BAD_MAXVAL;
      end else if (phase_in != PH_PAYLOAD || !seen_ok) begin
         stat = ST_SIZE;
      end else begin
         stat = ST_OK;
      end
   end

   always_comb begin
      pix_rsp              = '0;
      pix_rsp.pixel_rgba   = {8'h00, byte_ff, part_ff};
      stat_rsp             = '0;
      stat_rsp.is_status   = 1'b1;
      stat_rsp.status      = stat;
      stat_rsp.image_width = sat16(fw);
      stat_rsp.image_height = sat16(fh);
      stat_rsp.last        = 1'b1;
   end

   assign push_valid = (pend_ff && push_ready) || (fire && (pix_fire || eof_ff));
   assign push_data  = pend_ff ? pend_data_ff : (pix_fire ? pix_rsp : stat_rsp);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC0;
         cmt_ff   <= 1'b0;
         acc_ff   <= '0;
         w_ff     <= '0;
         h_ff     <= '0;
         m_ff     <= '0;
         tp_ff    <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         over_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (fire) begin
         if (eof_ff) begin
            phase_ff <= PH_MAGIC0;
            cmt_ff   <= 1'b0;
            acc_ff   <= '0;
            w_ff     <= '0;
            h_ff     <= '0;
            m_ff     <= '0;
            tp_ff    <= '0;
            col_ff   <= '0;
            row_ff   <= '0;
            over_ff  <= 1'b0;
            // last byte finished a pixel: status word is held and pushed after it
            pend_ff  <= pix_fire;
         end else begin
            phase_ff <= phase_in;
            cmt_ff   <= cmt_in;
            acc_ff   <= acc_in;
            w_ff     <= w_in;
            h_ff     <= h_in;
            m_ff     <= m_in;
            tp_ff    <= tp_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            over_ff  <= over_in;
         end
      end else if (pend_ff && push_ready) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         part_ff <= part_in;
      end
      if (fire && eof_ff) begin
         pend_data_ff <= stat_rsp;
      end
   end

endmodule

FILE: hw/rtl/ppd_rsp_fifo.sv
// Two-entry result queue between the parser and the result channel.
module ppd_rsp_fifo import ppd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  rsp_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data
);

   rsp_type     mem_ff [2];
   logic [1:0]  count_ff;
   logic        wr_ff;
   logic        rd_ff;
   logic        push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
